// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the statistics core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmms: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmms: next-cycle check failed");

`endif

// File: design/dmms_pkg.sv
// ----------------------------------------------------------------------------
// dmms_pkg
// Types and fixed widths shared by the statistics core modules.
// ----------------------------------------------------------------------------
package dmms_pkg;

  // Width of one sample word and of min, max and average.
  localparam int SAMPLE_W = 16;
  // Fraction bits fed into the square root (Q.8 result needs 16).
  localparam int FRAC_W   = 16;
  // Width of the reported deviation.
  localparam int DEV_W    = 23;
  // Widths of the total and count result fields.
  localparam int TOTAL_W  = 32;
  localparam int COUNT_W  = 17;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic acc;        // take one sample into the running sums
    logic clr;        // clear the running state after a result
    logic div_load;   // start the shared divider
    logic div_sel_s;  // divider numerator: 0 = |sum|, 1 = S * 2^16
    logic cap_q;      // capture mean magnitude and remainder
    logic mul_sq;     // q * q
    logic mul_nsq;    // n * q^2
    logic mul_qr;     // q * r
    logic sub;        // form the sum of squared deviations
    logic sqrt_load;  // start the square root on the divider quotient
    logic out_load;   // register the result word
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

// File: design/dmms_ctrl.sv
// ----------------------------------------------------------------------------
// dmms_ctrl
// Sequencer: accumulates while idle, then walks the finishing steps.
// ----------------------------------------------------------------------------
module dmms_ctrl
  import dmms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [8:0] {
    ST_ACC     = 9'b000000001,
    ST_LOAD1   = 9'b000000010,
    ST_DIV1    = 9'b000000100,
    ST_MUL_SQ  = 9'b000001000,
    ST_MUL_NSQ = 9'b000010000,
    ST_MUL_QR  = 9'b000100000,
    ST_SUB     = 9'b001000000,
    ST_LOAD2   = 9'b010000000,
    ST_ROOT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   div2_r, div2_nxt;

  assign busy = (state_r != ST_ACC);

  always_comb begin
    state_nxt = state_r;
    div2_nxt  = div2_r;
    cmd       = '0;
    case (state_r)
      ST_ACC: begin
        cmd.acc = start;
        if (start && in_last) begin
          state_nxt = ST_LOAD1;
        end
      end
      ST_LOAD1: begin
        cmd.div_load = 1'b1;
        div2_nxt     = 1'b0;
        state_nxt    = ST_DIV1;
      end
      ST_DIV1: begin
        // Shared by both divisions; div2_r tells which one is running.
        if (sts.div_done) begin
          if (div2_r) begin
            cmd.sqrt_load = 1'b1;
            state_nxt     = ST_ROOT;
          end else begin
            cmd.cap_q = 1'b1;
            state_nxt = ST_MUL_SQ;
          end
        end
      end
      ST_MUL_SQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = ST_MUL_NSQ;
      end
      ST_MUL_NSQ: begin
        cmd.mul_nsq = 1'b1;
        state_nxt   = ST_MUL_QR;
      end
      ST_MUL_QR: begin
        cmd.mul_qr = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_LOAD2;
      end
      ST_LOAD2: begin
        cmd.div_load  = 1'b1;
        cmd.div_sel_s = 1'b1;
        div2_nxt      = 1'b1;
        state_nxt     = ST_DIV1;
      end
      ST_ROOT: begin
        if (sts.sqrt_done) begin
          cmd.out_load = 1'b1;
          cmd.clr      = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      div2_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div2_r  <= div2_nxt;
    end
  end

endmodule

// File: design/dmms_div.sv
// ----------------------------------------------------------------------------
// dmms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmms_div
  import dmms_pkg::*;
#(
  parameter int NUM_W = 65,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             borrow;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, den_r};
  assign borrow  = diff[DEN_W+1];
  assign rem_nxt = borrow ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NUM_W-2:0], ~borrow};
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// File: design/dmms_sqrt.sv
// ----------------------------------------------------------------------------
// dmms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dmms_sqrt
  import dmms_pkg::*;
#(
  parameter int IN_W = 66
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [IN_W-1:0]   x,
  output logic [IN_W/2-1:0] root,
  output logic              done
);

  localparam int RW    = IN_W / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [IN_W-1:0]  x_r;
  logic [RW:0]      rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [RW+2:0]    rem_sh;
  logic [RW+2:0]    trial;
  logic [RW+2:0]    rem_diff;
  logic             ge;

  // Bring down two radicand bits and test the trial value 4*root + 1.
  assign rem_sh   = {rem_r, x_r[IN_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_diff = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        cnt_r <= CNT_W'(RW);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      x_r    <= {x_r[IN_W-3:0], 2'b00};
      rem_r  <= rem_diff[RW:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// File: design/dmms_dp.sv
// ----------------------------------------------------------------------------
// dmms_dp
// Datapath: running min, max, sum and sum of squares, the shared multiplier,
// divider and square root, and the result word register.
// ----------------------------------------------------------------------------
module dmms_dp
  import dmms_pkg::*;
#(
  parameter int MAX_COUNT = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [TOTAL_W-1:0]  out_total,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic        [DEV_W-1:0]    out_deviation_q8,
  output logic        [COUNT_W-1:0]  out_sample_count,
  output logic                       out_dropped
);

  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int SSQ_W = 2 * SAMPLE_W + CW;
  localparam int NUM_W = SSQ_W + FRAC_W;
  localparam int SQ_W  = NUM_W + (NUM_W % 2);
  localparam int RW    = SQ_W / 2;
  localparam int QW    = SAMPLE_W + 1;
  localparam int AW    = (QW > CW) ? QW : CW;
  localparam int BW    = 2 * QW;
  localparam int PW    = AW + BW;
  localparam int TW    = (SUM_W > TOTAL_W + 1) ? SUM_W : TOTAL_W + 1;
  localparam int NW    = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [CW-1:0]        CNT_MAX = CW'(MAX_COUNT);
  localparam logic signed [TW-1:0] TOT_HI  = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] TOT_LO  = TW'(-64'sd2147483648);

  // Running state.
  logic [CW-1:0]                cnt_r;
  logic signed [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SSQ_W-1:0]             ssq_r, ssq_nxt;
  logic                         ovf_r;
  logic signed [SAMPLE_W-1:0]   min_r, max_r;
  logic signed [2*SAMPLE_W-1:0] xsq;
  logic                         room;

  // Finishing state.
  logic [QW-1:0]    q_r;
  logic [CW-1:0]    r_r;
  logic             neg_r;
  logic [BW-1:0]    sq_r;
  logic [SSQ_W-1:0] nsq_r, qr_r, s_r;
  logic [SSQ_W+1:0] s_nxt;
  logic             out_valid_r;

  // Shared units.
  logic [AW-1:0]    mul_a;
  logic [BW-1:0]    mul_b;
  logic [PW-1:0]    prod;
  logic [SUM_W-1:0] sum_mag;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [CW-1:0]    div_rem;
  logic             div_done;
  logic [RW-1:0]    root;
  logic             sqrt_done;

  // Result formatting.
  logic signed [TW-1:0]       sum_ext;
  logic [TOTAL_W-1:0]         tot_sat;
  logic [QW-1:0]              mean_s;
  logic [DEV_W-1:0]           dev_sat;
  logic [NW-1:0]              cnt_ext;

  assign room    = (cnt_r < CNT_MAX);
  assign xsq     = in_sample * in_sample;
  assign sum_nxt = sum_r + SUM_W'(in_sample);
  assign ssq_nxt = ssq_r + SSQ_W'(unsigned'(xsq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      ssq_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
      if (cmd.clr) begin
        cnt_r <= '0;
        sum_r <= '0;
        ssq_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.acc) begin
        if (room) begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_nxt;
          ssq_r <= ssq_nxt;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && room) begin
      if (cnt_r == '0) begin
        min_r <= in_sample;
        max_r <= in_sample;
      end else begin
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
      end
    end
  end

  // The first division yields |m| and |r| with sum = n*m + r; both share the
  // sign of the sum, so S = sumsq - n*m*m - 2*m*r works on magnitudes alone.
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_num = cmd.div_sel_s ? {s_r, {FRAC_W{1'b0}}} : NUM_W'(sum_mag);

  dmms_div #(
    .NUM_W (NUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.div_load),
    .num   (div_num),
    .den   (cnt_r),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  dmms_sqrt #(
    .IN_W (SQ_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.sqrt_load),
    .x     (SQ_W'(div_quo)),
    .root  (root),
    .done  (sqrt_done)
  );

  assign sts = {div_done, sqrt_done};

  assign mul_a = cmd.mul_nsq ? AW'(cnt_r) : AW'(q_r);
  assign mul_b = cmd.mul_nsq ? sq_r : (cmd.mul_qr ? BW'(r_r) : BW'(q_r));
  assign prod  = mul_a * mul_b;
  assign s_nxt = (SSQ_W+2)'(ssq_r) - (SSQ_W+2)'(nsq_r) - {1'b0, qr_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.cap_q) begin
      q_r   <= div_quo[QW-1:0];
      r_r   <= div_rem;
      neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.mul_sq) begin
      sq_r <= prod[BW-1:0];
    end
    if (cmd.mul_nsq) begin
      nsq_r <= prod[SSQ_W-1:0];
    end
    if (cmd.mul_qr) begin
      qr_r <= prod[SSQ_W-1:0];
    end
    if (cmd.sub) begin
      s_r <= s_nxt[SSQ_W-1:0];
    end
  end

  assign sum_ext = TW'(sum_r);
  assign tot_sat = (sum_ext > TOT_HI) ? {1'b0, {(TOTAL_W-1){1'b1}}} :
                   (sum_ext < TOT_LO) ? {1'b1, {(TOTAL_W-1){1'b0}}} :
                   sum_ext[TOTAL_W-1:0];
  assign mean_s  = neg_r ? (~q_r + 1'b1) : q_r;
  assign dev_sat = (|root[RW-1:DEV_W]) ? {DEV_W{1'b1}} : root[DEV_W-1:0];
  assign cnt_ext = NW'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_minimum      <= min_r;
      out_maximum      <= max_r;
      out_total        <= tot_sat;
      out_average      <= mean_s[SAMPLE_W-1:0];
      out_deviation_q8 <= dev_sat;
      out_sample_count <= cnt_ext[COUNT_W-1:0];
      out_dropped      <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/dataset_min_max_mean_stddev_core.sv
// ----------------------------------------------------------------------------
// dataset_min_max_mean_stddev_core
// Minimum, maximum, total, mean and population standard deviation of a set.
// ----------------------------------------------------------------------------
// Samples of a data set are written one word at a time with start while busy
// is low; in_last marks the final sample of the set. While a set is being
// collected the core takes one sample every cycle. The final sample raises
// busy while the core finishes the set, mostly in the two bit-serial divisions
// over W = 2*16 + clog2(MAX_COUNT+1) + 16 bits, the shared divider width, and
// in the bit-serial square root. When busy falls, the result word appears on
// the out_ ports for exactly one cycle, marked by out_valid; there is no way to
// stall it, so the receiver must capture it in that cycle. A new set may start
// in the same cycle the result is shown. Samples beyond MAX_COUNT in a set are
// discarded and reported through out_dropped; the total saturates to the
// signed 32-bit range and the deviation is given in unsigned Q.8, floored.
// ----------------------------------------------------------------------------
module dataset_min_max_mean_stddev_core
  import dmms_pkg::*;
#(
  parameter int MAX_COUNT = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Sample channel.
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  // Result channel.
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [TOTAL_W-1:0]  out_total,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic        [DEV_W-1:0]    out_deviation_q8,
  output logic        [COUNT_W-1:0]  out_sample_count,
  output logic                       out_dropped
);

  // The sequencer drives the datapath through a command word and watches
  // the completion flags of the divider and the square root.
  cmd_t cmd;
  sts_t sts;

  dmms_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Accumulators, the shared arithmetic units and the result register.
  dmms_dp #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_total        (out_total),
    .out_average      (out_average),
    .out_deviation_q8 (out_deviation_q8),
    .out_sample_count (out_sample_count),
    .out_dropped      (out_dropped)
  );

endmodule

// File: design/dmms_checker.sv
// ----------------------------------------------------------------------------
// dmms_checker
// Port-level checks of the statistics core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmms_checker
  import dmms_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_last,
  input logic                       out_valid,
  input logic signed [SAMPLE_W-1:0] out_minimum,
  input logic signed [SAMPLE_W-1:0] out_maximum,
  input logic signed [SAMPLE_W-1:0] out_average
);

  // The final sample of a set always starts the finishing sequence.
  `DMMS_ASSERT_NXT(a_last_sets_busy, clk, rst_n, start && !busy && in_last, busy)

  // A result is shown only once the core is ready for a new set again.
  `DMMS_ASSERT_IMP(a_result_when_idle, clk, rst_n, out_valid, !busy)

  // Each set gives a single one-cycle result.
  `DMMS_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

  // The truncated mean lies between the smallest and largest sample.
  `DMMS_ASSERT_IMP(a_mean_in_range, clk, rst_n, out_valid,
                   (out_minimum <= out_average) && (out_average <= out_maximum))

endmodule

bind dataset_min_max_mean_stddev_core dmms_checker u_dmms_checker (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the data set statistics core.
// ----------------------------------------------------------------------------
// Sample words go in through the start/busy command channel, and the single
// result word of each data set is compared field by field with a model kept
// in this bench. The model folds every accepted word into its own running
// minimum, maximum, sum and sum of squares. On the last word of a set it works
// out the truncated mean, the population deviation in Q.8 and the saturated
// total. A short directed table covers the corner cases first. Random sets of
// varied shape follow, from single words to a few dozen, with extremes,
// narrow clusters and constant runs mixed in.
// ----------------------------------------------------------------------------
module tb;
  import dmms_pkg::*;

  // The core is built at its default capacity, so a full set holds 65536 words.
  localparam int MAX_SET = 65536;
  // Number of words drawn in the random small sets after the directed table.
  localparam int RANDOM_WORDS = 1600;
  localparam int DIRECTED_ROWS = 22;
  // A result follows its last word once the finishing sequence ends; wait well past that.
  localparam int DRAIN_CYCLES = 400;
  // Even if every word closed a set and came after the longest sender gap,
  // the run stays several times below this bound.
  localparam longint CYCLE_LIMIT = 2_000_000;

  localparam logic signed [SAMPLE_W-1:0] SMP_LO = -(2 ** (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] SMP_HI = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint TOTAL_HI = (longint'(1) <<< (TOTAL_W - 1)) - 1;
  localparam longint TOTAL_LO = -(longint'(1) <<< (TOTAL_W - 1));
  localparam longint unsigned DEV_CEIL = (64'd1 << DEV_W) - 1;

  // One result word, laid out like the out_ ports.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [SAMPLE_W-1:0] average;
    logic        [DEV_W-1:0]    deviation_q8;
    logic        [COUNT_W-1:0]  sample_count;
    logic                       dropped;
  } set_summary_t;

  // One row of the directed table. Where known is set, the row closes a set
  // whose result is written out by hand instead of coming from the model.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       known;
    set_summary_t               summary;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic busy;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_minimum;
  logic signed [SAMPLE_W-1:0] out_maximum;
  logic signed [TOTAL_W-1:0]  out_total;
  logic signed [SAMPLE_W-1:0] out_average;
  logic        [DEV_W-1:0]    out_deviation_q8;
  logic        [COUNT_W-1:0]  out_sample_count;
  logic                       out_dropped;

  // These travel with each word so that the monitor, which sees the accept,
  // knows whether a hand-written result goes with it.
  logic row_known = 1'b0;
  set_summary_t row_summary = '0;

  // Running state of the model for the set now being collected.
  int unsigned set_count = 0;
  logic signed [SAMPLE_W-1:0] set_min = '0;
  logic signed [SAMPLE_W-1:0] set_max = '0;
  longint set_sum = 0;
  longint unsigned set_sumsq = 0;
  logic set_dropped = 1'b0;

  // Results still owed by the core, oldest first.
  set_summary_t pending_summaries[$];

  stim_row_t directed_rows [DIRECTED_ROWS];
  int burst_left = 0;
  int words_sent = 0;
  int words_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  longint unsigned widest_deviation = 0;
  longint cycles = 0;

  dataset_min_max_mean_stddev_core #(
    .MAX_COUNT(MAX_SET)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_minimum     (out_minimum),
    .out_maximum     (out_maximum),
    .out_total       (out_total),
    .out_average     (out_average),
    .out_deviation_q8(out_deviation_q8),
    .out_sample_count(out_sample_count),
    .out_dropped     (out_dropped)
  );

  always #10 clk = ~clk;

  // Integer square root, floored, one result bit per pass.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned root = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Folds one accepted word into the running set. On the last word it returns
  // the result the core must give and clears the set for the next one.
  task automatic fold_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                             output logic done, output set_summary_t res);
    longint sq, mean, tot;
    longint unsigned n, um, usum, spread, scaled, dev;
    done = 1'b0;
    res = '0;
    // A full set ignores further words but remembers that it did.
    if (set_count < MAX_SET) begin
      if (set_count == 0) begin
        set_min = smp;
        set_max = smp;
      end else begin
        if (smp < set_min) set_min = smp;
        if (smp > set_max) set_max = smp;
      end
      sq = longint'(smp) * longint'(smp);
      set_sum += longint'(smp);
      set_sumsq += sq;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      n = set_count;
      // Signed division truncates toward zero, so -7/2 gives -3.
      mean = set_sum / longint'(n);
      um = mean;
      usum = set_sum;
      // Squared deviations around the truncated mean, in wrapping 64-bit terms.
      spread = set_sumsq - 2 * um * usum + n * um * um;
      scaled = ((spread / n) << 16) + (((spread % n) << 16) / n);
      dev = floor_root(scaled);
      if (dev > DEV_CEIL) dev = DEV_CEIL;
      tot = set_sum;
      if (tot > TOTAL_HI) tot = TOTAL_HI;
      if (tot < TOTAL_LO) tot = TOTAL_LO;
      res.minimum = set_min;
      res.maximum = set_max;
      res.total = tot[TOTAL_W-1:0];
      res.average = um[SAMPLE_W-1:0];
      res.deviation_q8 = dev[DEV_W-1:0];
      res.sample_count = n[COUNT_W-1:0];
      res.dropped = set_dropped;
      done = 1'b1;
      set_count = 0;
      set_min = '0;
      set_max = '0;
      set_sum = 0;
      set_sumsq = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Puts one word on the channel and returns at the edge that accepts it. The
  // sender runs in bursts; between bursts start drops for a few cycles, which
  // lands the gaps both inside a set and during the long busy after a last
  // word. Now and then a long burst gives a stretch with no idling at all.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                           input logic known, input set_summary_t summary);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    in_sample <= smp;
    in_last <= lst;
    row_known <= known;
    row_summary <= summary;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // One random set: mostly short, sometimes a few dozen words. The content is
  // any bit pattern, the two extremes only, a narrow cluster, or a constant.
  task automatic send_random_set();
    int unsigned len, flavor;
    logic signed [SAMPLE_W-1:0] base, smp;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
    flavor = $urandom_range(0, 4);
    base = ($urandom_range(0, 2) == 0) ? '0 : SAMPLE_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (flavor)
        0, 1: smp = SAMPLE_W'($urandom);
        2: smp = $urandom_range(0, 1) ? SMP_HI : SMP_LO;
        3: smp = base + SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
        default: smp = base;
      endcase
      send_word(smp, i == len - 1, 1'b0, '0);
    end
  endtask

  // Monitor. Both the accept and the result are judged on values from before
  // the edge, so the order of processes within the step does not matter. The
  // model runs first, which keeps the queue right even if a result were ever
  // to follow its last word at once.
  always @(posedge clk) begin
    logic done;
    set_summary_t predicted, want, got;
    if (rst_n) begin
      if (start && !busy) begin
        fold_sample(in_sample, in_last, done, predicted);
        words_taken++;
        if (done) pending_summaries.push_back(row_known ? row_summary : predicted);
      end
      if (out_valid) begin
        got = '{out_minimum, out_maximum, out_total, out_average, out_deviation_q8,
                out_sample_count, out_dropped};
        if (pending_summaries.size() == 0) begin
          $display("%0t: result word with none expected: min %0d max %0d total %0d",
                   $time, got.minimum, got.maximum, got.total);
          mismatches++;
        end else begin
          want = pending_summaries.pop_front();
          check_field("minimum", want.minimum, got.minimum);
          check_field("maximum", want.maximum, got.maximum);
          check_field("total", want.total, got.total);
          check_field("average", want.average, got.average);
          check_field("deviation_q8", want.deviation_q8, got.deviation_q8);
          check_field("sample_count", want.sample_count, got.sample_count);
          check_field("dropped", want.dropped, got.dropped);
          results_checked++;
          if (want.deviation_q8 > widest_deviation) widest_deviation = want.deviation_q8;
        end
      end
    end
  end

  // Watchdog: a hung channel or a missing result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_summaries.size());
      $display("dataset_min_max_mean_stddev_core test failed");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      // Sets of one word: zero and both extremes. One word has no spread.
      '{'0,     1'b1, 1'b1, '{'0, '0, '0, '0, '0, 17'd1, 1'b0}},
      '{SMP_LO, 1'b1, 1'b1, '{SMP_LO, SMP_LO, -32'sd32768, SMP_LO, '0, 17'd1, 1'b0}},
      '{SMP_HI, 1'b1, 1'b1, '{SMP_HI, SMP_HI, 32'sd32767, SMP_HI, '0, 17'd1, 1'b0}},
      // Both extremes in either order: the widest spread two words can have.
      '{SMP_LO, 1'b0, 1'b0, '0},
      '{SMP_HI, 1'b1, 1'b0, '0},
      '{SMP_HI, 1'b0, 1'b0, '0},
      '{SMP_LO, 1'b1, 1'b0, '0},
      // Minus one and one: mean zero, deviation exactly one, 256 in Q.8.
      '{-16'sd1, 1'b0, 1'b0, '0},
      '{16'sd1,  1'b1, 1'b1, '{-16'sd1, 16'sd1, '0, '0, 23'd256, 17'd2, 1'b0}},
      // A negative total that does not divide evenly: the mean truncates to -3,
      // and a negative first word must also load the maximum.
      '{-16'sd3, 1'b0, 1'b0, '0},
      '{-16'sd4, 1'b1, 1'b0, '0},
      // A constant positive set: the first word must load the minimum.
      '{16'sd5, 1'b0, 1'b0, '0},
      '{16'sd5, 1'b0, 1'b0, '0},
      '{16'sd5, 1'b0, 1'b0, '0},
      '{16'sd5, 1'b1, 1'b1, '{16'sd5, 16'sd5, 32'sd20, 16'sd5, '0, 17'd4, 1'b0}},
      // The minimum moves after the first word; the maximum stays on the first word.
      '{16'sd100,  1'b0, 1'b0, '0},
      '{-16'sd100, 1'b0, 1'b0, '0},
      '{16'sd7,    1'b0, 1'b0, '0},
      '{'0,        1'b1, 1'b0, '0},
      // A total wider than a sample word.
      '{SMP_HI, 1'b0, 1'b0, '0},
      '{SMP_HI, 1'b0, 1'b0, '0},
      '{SMP_HI, 1'b1, 1'b1, '{SMP_HI, SMP_HI, 32'sd98301, SMP_HI, '0, 17'd3, 1'b0}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_word(directed_rows[i].sample, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].summary);

    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) send_random_set();
    start <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d sample words and checked %0d result words.", words_taken,
             results_checked);
    $display("Largest deviation seen was %0d in Q.8.", widest_deviation);
    if (mismatches == 0) begin
      $display("dataset_min_max_mean_stddev_core test passed");
    end else begin
      $display("dataset_min_max_mean_stddev_core test failed");
    end
    $finish;
  end

endmodule
